/* rtl/core/mspd_pkg.sv */
// Shared types and constants of the PI speed to duty controller.
package mspd_pkg;

    localparam int GAIN_W    = 24;
    localparam int DUTY_W    = 16;
    localparam int ESUM_W    = 32;
    localparam int CFG_IDX_W = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_I_GAIN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECT = 4'd3;

    // reset values of the gains: about 0.001 and 0.0001 with 24 fraction bits
    localparam logic [GAIN_W-1:0] P_GAIN_RST = 24'd16777;
    localparam logic [GAIN_W-1:0] I_GAIN_RST = 24'd1678;

    // Q15 limits: 0.95 and 0.15
    localparam int Q15_095 = 31129;
    localparam int Q15_015 = 4915;

    typedef struct packed {
        logic [GAIN_W-1:0] p_gain;
        logic [GAIN_W-1:0] i_gain;
    } gains_t;

    typedef struct packed {
        logic signed [ESUM_W-1:0] error_sum;
        logic signed [DUTY_W-1:0] duty_level;
    } loop_state_t;

endpackage

/* rtl/core/mspd_pi_step.sv */
// One PI control step: error, saturating sum, increment and duty clamp.
module mspd_pi_step #(
    parameter int SPEED_WIDTH    = 16,
    parameter int GAIN_FRAC_BITS = 24
) (
    input  logic signed [SPEED_WIDTH-1:0] target_speed,
    input  logic signed [SPEED_WIDTH-1:0] measured_speed,
    input  mspd_pkg::gains_t              gains,
    input  mspd_pkg::loop_state_t         state_cur,
    output mspd_pkg::loop_state_t         state_nxt
);
    import mspd_pkg::*;

    localparam int E_W   = SPEED_WIDTH + 1;
    localparam int ACC_W = ((E_W > ESUM_W) ? E_W : ESUM_W) + 1;
    localparam int PP_W  = E_W + GAIN_W + 1;
    localparam int IP_W  = ESUM_W + GAIN_W + 1;
    localparam int S_W   = ((PP_W > IP_W) ? PP_W : IP_W) + 1;
    localparam int SH    = GAIN_FRAC_BITS - 15;
    localparam int Q_W   = S_W - SH;
    localparam int D_W   = DUTY_W + 1;

    logic signed [E_W-1:0]    err;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ESUM_W-1:0] sum_new;
    logic signed [PP_W-1:0]   prod_p;
    logic signed [IP_W-1:0]   prod_i;
    logic signed [S_W-1:0]    pi_sum;
    logic signed [S_W-1:0]    pi_adj;
    logic signed [Q_W-1:0]    q;
    logic signed [DUTY_W-1:0] inc;
    logic signed [D_W-1:0]    duty_raw;
    logic signed [D_W-1:0]    duty_lim;

    assign err = E_W'(target_speed) - E_W'(measured_speed);
    assign acc = ACC_W'(state_cur.error_sum) + ACC_W'(err);

    // saturate the sum to 32 bits when the upper bits disagree with the sign
    always_comb
    begin
        if (acc[ACC_W-1:ESUM_W-1] == {(ACC_W-ESUM_W+1){1'b0}} ||
            acc[ACC_W-1:ESUM_W-1] == {(ACC_W-ESUM_W+1){1'b1}})
        begin
            sum_new = acc[ESUM_W-1:0];
        end
        else if (acc[ACC_W-1])
        begin
            sum_new = {1'b1, {(ESUM_W-1){1'b0}}};
        end
        else
        begin
            sum_new = {1'b0, {(ESUM_W-1){1'b1}}};
        end
    end

    assign prod_p = PP_W'(err) * PP_W'($signed({1'b0, gains.p_gain}));
    assign prod_i = IP_W'(sum_new) * IP_W'($signed({1'b0, gains.i_gain}));
    assign pi_sum = S_W'(prod_p) + S_W'(prod_i);

    // bias negative sums so the shift truncates toward zero
    assign pi_adj = pi_sum[S_W-1] ? pi_sum + $signed(S_W'({SH{1'b1}})) : pi_sum;
    assign q      = pi_adj[S_W-1:SH];

    always_comb
    begin
        if (q > Q_W'(Q15_095))
        begin
            inc = DUTY_W'(Q15_095);
        end
        else if (q < -Q_W'(Q15_095))
        begin
            inc = -DUTY_W'(Q15_095);
        end
        else
        begin
            inc = q[DUTY_W-1:0];
        end
    end

    assign duty_raw = D_W'(state_cur.duty_level) + D_W'(inc);

    // clamp window follows the sign of the target
    always_comb
    begin
        duty_lim = duty_raw;
        if (target_speed > 0)
        begin
            if (duty_raw < D_W'(Q15_015))
                duty_lim = D_W'(Q15_015);
            else if (duty_raw > D_W'(Q15_095))
                duty_lim = D_W'(Q15_095);
        end
        else if (target_speed < 0)
        begin
            if (duty_raw < -D_W'(Q15_095))
                duty_lim = -D_W'(Q15_095);
            else if (duty_raw > -D_W'(Q15_015))
                duty_lim = -D_W'(Q15_015);
        end
        else
        begin
            if (duty_raw < $signed({1'b1, 1'b1, {(DUTY_W-1){1'b0}}}))
                duty_lim = $signed({1'b1, 1'b1, {(DUTY_W-1){1'b0}}});
            else if (duty_raw > $signed({1'b0, 1'b0, {(DUTY_W-1){1'b1}}}))
                duty_lim = $signed({1'b0, 1'b0, {(DUTY_W-1){1'b1}}});
        end
    end

    assign state_nxt.error_sum  = sum_new;
    assign state_nxt.duty_level = duty_lim[DUTY_W-1:0];

endmodule

/* rtl/core/motor_speed_pi_duty_core.sv */
// Top level of the PI speed controller that turns encoder speed into PWM duty.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  measured_speed
//  m_axis    out  m_axis_tvalid / m_axis_tready  duty (signed Q15)
//  cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
//  One item per cycle sustained while m_axis_tready stays high; each item passes through
//  the input register and the result register around one PI step.
//  The loop state (error sum, held duty) updates as an item moves into the result register.
//  A stalled result holds; the input register still takes one more item behind it.
//  While direct_duty is nonzero, accepted items are dropped and give no result.
//  Reset clears the loop state and loads the register reset values; cfg_ready stays high.
module motor_speed_pi_duty_core #(
    parameter int SPEED_WIDTH    = 16,
    parameter int GAIN_FRAC_BITS = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // s_axis_tdata: [SPEED_WIDTH-1:0] measured_speed, zero fill above
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SPEED_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // m_axis_tdata: [15:0] duty
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [mspd_pkg::DUTY_W-1:0]            m_axis_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mspd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [((SPEED_WIDTH > mspd_pkg::GAIN_W) ?
                   SPEED_WIDTH : mspd_pkg::GAIN_W)-1:0] cfg_data
);
    import mspd_pkg::*;

    logic                          in_vld_reg, in_vld_next;
    logic signed [SPEED_WIDTH-1:0] in_speed_reg;
    logic                          out_vld_reg, out_vld_next;
    logic signed [DUTY_W-1:0]      out_duty_reg;

    logic signed [SPEED_WIDTH-1:0] target_reg, target_next;
    gains_t                        gains_reg, gains_next;
    logic signed [DUTY_W-1:0]      direct_reg, direct_next;
    loop_state_t                   state_reg, state_next;
    loop_state_t                   step_state;

    logic loop_on;
    logic move;
    logic in_accept;
    logic cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign loop_on       = (direct_reg == '0);
    assign move          = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || move;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    mspd_pi_step #(
        .SPEED_WIDTH    (SPEED_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_step (
        .target_speed   (target_reg),
        .measured_speed (in_speed_reg),
        .gains          (gains_reg),
        .state_cur      (state_reg),
        .state_nxt      (step_state)
    );

    // advance the two-stage pipe; drop items while the loop is off
    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_accept)
            in_vld_next = loop_on;
        else if (move)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (move && loop_on)
            out_vld_next = 1'b1;
        else if (m_axis_tready)
            out_vld_next = 1'b0;
    end

    // register writes win over loop update; user must write only while idle, unenforced
    always_comb
    begin
        target_next = target_reg;
        gains_next  = gains_reg;
        direct_next = direct_reg;
        state_next  = state_reg;
        if (move && loop_on)
            state_next = step_state;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TARGET:
                begin
                    target_next = cfg_data[SPEED_WIDTH-1:0];
                    direct_next = '0;
                    state_next  = '0;
                end
                REG_P_GAIN: gains_next.p_gain = cfg_data[GAIN_W-1:0];
                REG_I_GAIN: gains_next.i_gain = cfg_data[GAIN_W-1:0];
                REG_DIRECT:
                begin
                    direct_next = cfg_data[DUTY_W-1:0];
                    target_next = '0;
                    state_next  = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            target_reg       <= '0;
            gains_reg.p_gain <= P_GAIN_RST;
            gains_reg.i_gain <= I_GAIN_RST;
            direct_reg       <= '0;
            state_reg        <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            target_reg  <= target_next;
            gains_reg   <= gains_next;
            direct_reg  <= direct_next;
            state_reg   <= state_next;
        end
    end

    // payload registers: load on acceptance and on a move while the loop is on
    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_speed_reg <= s_axis_tdata[SPEED_WIDTH-1:0];
        if (move && loop_on)
            out_duty_reg <= step_state.duty_level;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_duty_reg;

endmodule

/* rtl/core/mspd_checker.sv */
// Port-level checks of the PI speed controller and their bind.
module mspd_checker #(
    parameter int SPEED_WIDTH = 16
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [mspd_pkg::DUTY_W-1:0]            m_axis_tdata,
    input logic                                   cfg_valid,
    input logic                                   cfg_ready,
    input logic [mspd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input logic [((SPEED_WIDTH > mspd_pkg::GAIN_W) ?
                  SPEED_WIDTH : mspd_pkg::GAIN_W)-1:0] cfg_data
);
    import mspd_pkg::*;

    logic loop_off_reg, loop_off_next;

    // mirror the loop enable from the register writes seen on the port
    always_comb
    begin
        loop_off_next = loop_off_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TARGET)
                loop_off_next = 1'b0;
            else if (cfg_index == REG_DIRECT)
                loop_off_next = (cfg_data[DUTY_W-1:0] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            loop_off_reg <= 1'b0;
        else
            loop_off_reg <= loop_off_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or vanished");

    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while the result side is free");

    a_loop_off: assert property (@(posedge clk) disable iff (!rst_n)
        loop_off_reg && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result given while direct duty holds the loop off");

endmodule

bind motor_speed_pi_duty_core mspd_checker #(.SPEED_WIDTH(SPEED_WIDTH)) u_mspd_checker (.*);

/* tb/sv/motor_speed_pi_duty_core_test.sv */
// Self-checking testbench for the PI speed to duty controller core.
module motor_speed_pi_duty_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mspd_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 12;
    localparam int FRAC_BITS     = 24;
    localparam int Q15_SHIFT     = FRAC_BITS - 15;
    localparam int MAX_WAIT      = 12;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_TICKS  = 1550;
    localparam int SHOW_LIMIT    = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_DIRECT + 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = '1;

    localparam logic signed [15:0] SPEED_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SPEED_MIN = 16'sh8000;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;
    // proportional gain that turns an error of one count into exactly 0.95
    localparam logic [GAIN_W-1:0]  GAIN_EXACT_095 = GAIN_W'(Q15_095 << Q15_SHIFT);

    localparam longint ESUM_MAX = 64'sd2147483647;
    localparam longint ESUM_MIN = -64'sd2147483648;
    localparam longint DUTY_MAX = 64'sd32767;
    localparam longint DUTY_MIN = -64'sd32768;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;     // [15:0] measured_speed
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [15:0] duty
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAIN_W-1:0]    cfg_data  = '0;

    motor_speed_pi_duty_core #(
        .SPEED_WIDTH    (16),
        .GAIN_FRAC_BITS (FRAC_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Controller predictor: its own copy of the registers and loop state.
    // ------------------------------------------------------------------
    logic signed [15:0] ctl_target;
    logic signed [15:0] ctl_direct;
    logic [GAIN_W-1:0]  ctl_pgain;
    logic [GAIN_W-1:0]  ctl_igain;
    longint             ctl_esum;    // always held inside the signed 32-bit range
    logic signed [15:0] ctl_duty;

    // duties still owed by the block, oldest first
    logic [15:0] duty_expected[$];

    int fail_count     = 0;
    int results_seen   = 0;
    int ticks_closed   = 0;
    int ticks_dropped  = 0;
    int reg_writes     = 0;
    int random_ticks   = 0;
    int src_max_gap    = MAX_WAIT;
    int sink_max_stall = MAX_WAIT;

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void ctl_reset();
        ctl_target = '0;
        ctl_direct = '0;
        ctl_pgain  = P_GAIN_RST;
        ctl_igain  = I_GAIN_RST;
        ctl_esum   = 0;
        ctl_duty   = '0;
    endfunction

    // Target and direct-duty writes restart the loop from zero; each one
    // also cancels the other mode. Unknown indexes change nothing.
    function automatic void ctl_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] d);
        case (idx)
            REG_TARGET:
            begin
                ctl_target = d[15:0];
                ctl_direct = '0;
                ctl_esum   = 0;
                ctl_duty   = '0;
            end
            REG_P_GAIN: ctl_pgain = d;
            REG_I_GAIN: ctl_igain = d;
            REG_DIRECT:
            begin
                ctl_direct = d[15:0];
                ctl_target = '0;
                ctl_esum   = 0;
                ctl_duty   = '0;
            end
            default: ;
        endcase
    endfunction

    // One control tick. Returns 0 when the loop is off and the item is dropped.
    function automatic bit ctl_tick(logic [15:0] speed, output logic [15:0] duty);
        longint err;
        longint acc;
        longint step;
        longint nxt;
        duty = '0;
        if (ctl_direct != 0)
            return 1'b0;
        err      = longint'(ctl_target) - longint'($signed(speed));
        ctl_esum = clip(ctl_esum + err, ESUM_MIN, ESUM_MAX);
        acc      = err * longint'(ctl_pgain) + ctl_esum * longint'(ctl_igain);
        // drop the extra fraction bits, rounding toward zero
        if (acc < 0)
            step = -((-acc) >>> Q15_SHIFT);
        else
            step = acc >>> Q15_SHIFT;
        step = clip(step, -Q15_095, Q15_095);
        nxt  = longint'(ctl_duty) + step;
        if (ctl_target > 0)
            nxt = clip(nxt, Q15_015, Q15_095);
        else if (ctl_target < 0)
            nxt = clip(nxt, -Q15_095, -Q15_015);
        else
            nxt = clip(nxt, DUTY_MIN, DUTY_MAX);
        ctl_duty = nxt[15:0];
        duty     = ctl_duty;
        return 1'b1;
    endfunction

    function automatic void flag_failure(string msg);
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted duty must match the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_duty
        logic [15:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (duty_expected.size() == 0)
                flag_failure($sformatf("duty %0d with nothing expected", $signed(m_axis_tdata)));
            else
            begin
                want = duty_expected.pop_front();
                if (m_axis_tdata !== want)
                    flag_failure($sformatf("duty mismatch: expected %0d, got %0d",
                                           $signed(want), $signed(m_axis_tdata)));
            end
        end
    end

    // Result sink: draw a stall before each item, then hold ready until it moves.
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, sink_max_stall);
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Inputs move on the falling edge; handshakes are seen on the
    // rising edge. Valid stays high from one item to the next when no gap
    // is drawn, so it is never dropped and raised in the same step.
    // ------------------------------------------------------------------
    task automatic send_speed(input logic [15:0] speed, input bit fixed,
                              input logic [15:0] typed);
        int gap;
        logic [15:0] duty;
        gap = $urandom_range(0, src_max_gap);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= speed;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        // item taken at this edge: predict it now, in acceptance order
        if (ctl_tick(speed, duty))
        begin
            duty_expected.push_back(fixed ? typed : duty);
            ticks_closed++;
        end
        else
            ticks_dropped++;
    endtask

    // Stop sending, wait for every owed duty, then let dropped items drain too.
    task automatic settle_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (duty_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        ctl_write(idx, d);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed plan: register writes and speed items, with the duty typed
    // in only where it follows from a clamp or from the cleared state.
    // ------------------------------------------------------------------
    typedef enum logic {ROW_WRITE, ROW_SPEED} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [GAIN_W-1:0]    data;
        bit                   fixed;
        logic [15:0]          duty;
    } stim_row_t;

    stim_row_t plan[$];

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] d);
        stim_row_t r;
        r.kind  = ROW_WRITE;
        r.index = idx;
        r.data  = d;
        r.fixed = 1'b0;
        r.duty  = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_speed(logic [15:0] v, bit fixed = 1'b0, logic [15:0] d = '0);
        stim_row_t r;
        r.kind  = ROW_SPEED;
        r.index = REG_TARGET;
        r.data  = GAIN_W'(v);
        r.fixed = fixed;
        r.duty  = d;
        plan.push_back(r);
    endfunction

    function automatic void build_plan();
        // reset state, zero target: no error, no duty
        add_speed(16'd0, 1'b1, 16'd0);
        add_speed(SPEED_MAX);
        add_speed(SPEED_MIN);
        // full-scale error at maximum gain: increment and duty both clamp to 0.95
        add_write(REG_P_GAIN, GAIN_MAX);
        add_write(REG_I_GAIN, '0);
        add_write(REG_TARGET, GAIN_W'(SPEED_MAX));
        add_speed(SPEED_MIN, 1'b1, 16'(Q15_095));
        add_speed(SPEED_MAX);
        add_write(REG_TARGET, GAIN_W'(SPEED_MIN));
        add_speed(SPEED_MAX, 1'b1, 16'(-Q15_095));
        add_speed(SPEED_MIN);
        // no gain at all: duty sits on the inner limit of the target's side
        add_write(REG_P_GAIN, '0);
        add_write(REG_TARGET, 24'd100);
        add_speed(16'd100, 1'b1, 16'(Q15_015));
        add_write(REG_TARGET, 24'hFFFF9C);
        add_speed(16'hFF9C, 1'b1, 16'(-Q15_015));
        // increment landing exactly on +/-0.95, then zero-target saturation
        add_write(REG_P_GAIN, GAIN_EXACT_095);
        add_write(REG_TARGET, 24'd1);
        add_speed(16'd0, 1'b1, 16'(Q15_095));
        add_write(REG_TARGET, 24'd0);
        add_speed(16'd1, 1'b1, 16'(-Q15_095));
        add_speed(16'd1, 1'b1, 16'(DUTY_MIN));
        // a sum of -1 LSB in the fraction truncates to no step at all
        add_write(REG_P_GAIN, 24'd1);
        add_speed(16'd1, 1'b1, 16'(DUTY_MIN));
        // direct duty turns the loop off; items are dropped
        add_write(REG_I_GAIN, GAIN_MAX);
        add_write(REG_DIRECT, 24'h004000);
        add_speed(16'd0);
        add_speed(SPEED_MIN);
        add_write(REG_DIRECT, GAIN_W'(SPEED_MIN));
        add_speed(SPEED_MAX);
        add_write(REG_SPARE, 24'h123456);
        add_speed(16'd7);
        add_write(REG_DIRECT, '0);
        add_speed(16'd0, 1'b1, 16'd0);
        add_speed(SPEED_MAX);
        add_speed(SPEED_MIN);
    endfunction

    // ------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------
    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return GAIN_MAX;
            2: return GAIN_W'($urandom_range(0, 4095));
            3: return GAIN_W'($urandom_range(0, 65535));
            4: return GAIN_W'($urandom);
            default: return GAIN_W'(1) << $urandom_range(0, GAIN_W - 1);
        endcase
    endfunction

    function automatic logic [15:0] pick_target();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return SPEED_MAX;
            2: return SPEED_MIN;
            3: return 16'($signed($urandom_range(0, 4000)) - 2000);
            4: return 16'($signed($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    // Speeds near the target keep the loop in its linear range; a spread of
    // zero and the odd extreme throw in noise.
    function automatic logic [15:0] pick_speed(int spread);
        longint v;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? SPEED_MAX : SPEED_MIN;
        if (spread == 0)
            return 16'($urandom);
        v = longint'(ctl_target) + longint'($urandom_range(0, 2 * spread)) - spread;
        v = clip(v, DUTY_MIN, DUTY_MAX);
        return v[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int mode;
        int shape;
        int n;
        int spread;
        logic [15:0] v;

        ctl_reset();
        build_plan();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed table, registers written only once the block is idle
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                settle_idle();
                write_reg(plan[i].index, plan[i].data);
            end
            else
                send_speed(plan[i].data[15:0], plan[i].fixed, plan[i].duty);
        end

        // random phases: new settings, new idling mix, then a burst of ticks
        while (random_ticks < RANDOM_TICKS)
        begin
            settle_idle();
            mode           = $urandom_range(0, 3);
            src_max_gap    = mode[0] ? MAX_WAIT : 0;
            sink_max_stall = mode[1] ? MAX_WAIT : 0;
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_P_GAIN, pick_gain());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_I_GAIN, pick_gain());
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_SPARE, REG_TOP)), GAIN_W'($urandom));
            shape = $urandom_range(0, 9);
            if (shape == 0)
            begin
                v = 16'($urandom);
                if (v == 0)
                    v = 16'd1;
                write_reg(REG_DIRECT, {8'($urandom), v});
            end
            else if (shape == 1)
                write_reg(REG_DIRECT, {8'($urandom), 16'd0});
            else if (shape == 2 && ctl_direct == 0)
                ;   // keep sum and duty running across the gain change
            else
                write_reg(REG_TARGET, {8'($urandom), pick_target()});

            case ($urandom_range(0, 3))
                0: spread = 0;
                1: spread = 4;
                2: spread = 256;
                default: spread = 8192;
            endcase
            n = (ctl_direct != 0) ? $urandom_range(5, 15) : $urandom_range(40, 110);
            repeat (n) send_speed(pick_speed(spread), 1'b0, '0);
            if (ctl_direct == 0)
                random_ticks += n;
        end

        settle_idle();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (duty_expected.size() != 0)
            flag_failure($sformatf("%0d duties never arrived", duty_expected.size()));

        $display("Ran %0d closed-loop ticks, %0d ticks with the loop off, %0d register writes.",
                 ticks_closed, ticks_dropped, reg_writes);
        $display("Checked %0d duties over the clamps, truncation and random gains; %0d failures.",
                 results_seen, fail_count);
        if (fail_count == 0)
            $display("** motor_speed_pi_duty_core: PASSED **");
        else
            $display("** motor_speed_pi_duty_core: FAILED **");
        $finish;
    end

    // Watchdog: a correct run ends well inside this.
    initial
    begin : watchdog
        #(5_000_000);
        $display("** motor_speed_pi_duty_core: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/mspd_pkg.sv
rtl/core/mspd_pi_step.sv
rtl/core/motor_speed_pi_duty_core.sv
rtl/core/mspd_checker.sv
tb/sv/motor_speed_pi_duty_core_test.sv
